@@ rtl/wildcard_word_filter_unit_macros.svh @@
// Assertion macros used by the wildcard word filter port checker.
// Each macro expands to one labeled concurrent assertion clocked on aclk.
`ifndef WILDCARD_WORD_FILTER_UNIT_MACROS_SVH
`define WILDCARD_WORD_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define WWF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define WWF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/wwf_pkg.sv @@
// Package for the wildcard word filter: payload structs, register map
// and character constants. No dependencies.
package wwf_pkg;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       stream_end;
    } wwf_item_t;

    typedef struct packed {
        logic        word_done;
        logic        word_matched;
        logic [4:0]  word_length;
        logic [31:0] word_start;
        logic [31:0] match_tally;
        logic        stream_done;
    } wwf_result_t;

    localparam int ADDR_W      = 6;
    localparam int DATA_W      = 64;
    localparam int PAT_REGS    = 4;
    localparam int LETTER_CNT  = 26;
    localparam int OFFSET_W    = 32;
    localparam int OUT_LEN_W   = 5;
    localparam int OUT_COUNT_W = 32;

    // register indexes (byte address = 8 * index)
    localparam logic [2:0] REG_PAT0    = 3'd0;
    localparam logic [2:0] REG_PAT1    = 3'd1;
    localparam logic [2:0] REG_PAT2    = 3'd2;
    localparam logic [2:0] REG_PAT3    = 3'd3;
    localparam logic [2:0] REG_PAT_LEN = 3'd4;
    localparam logic [2:0] REG_EXCL    = 3'd5;
    localparam logic [2:0] REG_INCL    = 3'd6;

    localparam logic [4:0] PAT_LEN_RESET = 5'd2;
    localparam logic [4:0] PAT_LEN_MIN   = 5'd2;

    localparam logic [7:0] CHAR_LF       = 8'd10;
    localparam logic [7:0] CHAR_CR       = 8'd13;
    localparam logic [7:0] CHAR_WILDCARD = 8'd95;
    localparam logic [7:0] CHAR_UPPER_A  = 8'd65;
    localparam logic [7:0] CHAR_UPPER_Z  = 8'd90;
    localparam logic [7:0] CHAR_LOWER_A  = 8'd97;
    localparam logic [7:0] CHAR_LOWER_Z  = 8'd122;
    localparam logic [7:0] CASE_BIT      = 8'h20;

endpackage

@@ rtl/wildcard_word_filter_unit.sv @@
// Wildcard word filter: one dictionary byte per cycle in, one verdict per word or bare stream end out.
// Uses wwf_pkg for payload structs, register indexes and character constants.
//
// Takes one text byte every clock cycle with no gaps needed between words. The
// per-byte pattern compare, letter-mask update and end-of-word verdict are all
// combinational between the word state registers and the result register, so a
// result is registered in the cycle after the byte that ends the word (LF, CR, or any
// byte flagged stream_end). The result register frees up in the same cycle it
// is taken, so input stalls only while a finished result waits on m_ready.
// Configuration goes through a 64-bit APB port, registers at 8-byte strides.
module wildcard_word_filter_unit #(
    parameter int MAX_WORD_CHARS = 26,
    parameter int COUNT_BITS     = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  wwf_pkg::wwf_item_t         s_item,
    output logic                       m_valid,
    input  logic                       m_ready,
    output wwf_pkg::wwf_result_t       m_result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [wwf_pkg::ADDR_W-1:0] paddr,
    input  logic [wwf_pkg::DATA_W-1:0] pwdata,
    output logic [wwf_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import wwf_pkg::*;

    localparam int LEN_W = $clog2(MAX_WORD_CHARS + 2);
    localparam logic [LEN_W-1:0] LEN_SAT = LEN_W'(MAX_WORD_CHARS + 1);
    localparam logic [5:0] MAX_CHARS6 = 6'(MAX_WORD_CHARS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // configuration
    logic [PAT_REGS-1:0][DATA_W-1:0] pat_reg;
    logic [4:0]                      pat_len_reg;
    logic [LETTER_CNT-1:0]           excl_reg;
    logic [LETTER_CNT-1:0]           incl_reg;
    logic [2:0]                      reg_idx;
    logic                            cfg_wr;

    // word state
    logic [LETTER_CNT-1:0] letters_reg, letters_next;
    logic                  pos_ok_reg, pos_ok_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [OFFSET_W-1:0]   offset_reg, offset_next;
    logic [OFFSET_W-1:0]   start_reg, start_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    wwf_result_t out_reg, out_next;

    // per-byte datapath
    logic                  accept;
    logic                  is_term;
    logic                  is_letter;
    logic                  last;
    logic [7:0]            folded;
    logic [4:0]            letter_idx;
    logic [5:0]            pos6;
    logic [255:0]          pat_flat;
    logic [7:0]            pat_byte;
    logic                  cmp_en;
    logic [LETTER_CNT-1:0] letters_w;
    logic                  pos_ok_w;
    logic [LEN_W-1:0]      len_w;
    logic [OFFSET_W-1:0]   start_w;
    logic                  done;
    logic                  matched;
    logic                  pat_len_ok;
    logic [COUNT_BITS-1:0] count_w;

    assign reg_idx = paddr[ADDR_W-1:3];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_reg     <= '0;
            pat_len_reg <= PAT_LEN_RESET;
            excl_reg    <= '0;
            incl_reg    <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_PAT0:    pat_reg[0] <= pwdata;
                REG_PAT1:    pat_reg[1] <= pwdata;
                REG_PAT2:    pat_reg[2] <= pwdata;
                REG_PAT3:    pat_reg[3] <= pwdata;
                REG_PAT_LEN: pat_len_reg <= pwdata[4:0];
                REG_EXCL:    excl_reg <= pwdata[LETTER_CNT-1:0];
                REG_INCL:    incl_reg <= pwdata[LETTER_CNT-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PAT0:    prdata = pat_reg[0];
            REG_PAT1:    prdata = pat_reg[1];
            REG_PAT2:    prdata = pat_reg[2];
            REG_PAT3:    prdata = pat_reg[3];
            REG_PAT_LEN: prdata = DATA_W'(pat_len_reg);
            REG_EXCL:    prdata = DATA_W'(excl_reg);
            REG_INCL:    prdata = DATA_W'(incl_reg);
            default:     prdata = '0;
        endcase
    end

    // result register frees in the cycle it is taken
    assign s_ready  = !out_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    always_comb begin
        is_term   = (s_item.text_byte == CHAR_LF) || (s_item.text_byte == CHAR_CR);
        last      = s_item.stream_end;
        is_letter = ((s_item.text_byte >= CHAR_UPPER_A) && (s_item.text_byte <= CHAR_UPPER_Z))
                 || ((s_item.text_byte >= CHAR_LOWER_A) && (s_item.text_byte <= CHAR_LOWER_Z));
        folded     = s_item.text_byte | CASE_BIT;
        letter_idx = 5'(folded - CHAR_LOWER_A);

        pos6     = 6'(len_reg);
        pat_flat = pat_reg;
        pat_byte = pat_flat[pos6[4:0]*8 +: 8];
        cmp_en   = (pos6 < 6'd32) && (pos6 < MAX_CHARS6);

        letters_w = letters_reg;
        pos_ok_w  = pos_ok_reg;
        len_w     = len_reg;
        start_w   = start_reg;
        if (!is_term) begin
            if (len_reg == '0) begin
                start_w = offset_reg;
            end
            if (cmp_en && (pat_byte != CHAR_WILDCARD) && (pat_byte != s_item.text_byte)) begin
                pos_ok_w = 1'b0;
            end
            if (is_letter) begin
                letters_w[letter_idx] = 1'b1;
            end
            if (len_reg < LEN_SAT) begin
                len_w = len_reg + 1'b1;
            end
        end

        done       = (is_term || last) && (len_w != '0);
        pat_len_ok = (pat_len_reg >= PAT_LEN_MIN) && (6'(pat_len_reg) <= MAX_CHARS6);
        matched    = done && pos_ok_w && pat_len_ok
                  && (6'(len_w) == 6'(pat_len_reg))
                  && ((letters_w & excl_reg) == '0)
                  && ((letters_w & incl_reg) == incl_reg);
        count_w    = (matched && (count_reg != COUNT_MAX)) ? count_reg + 1'b1 : count_reg;

        out_next.word_done    = done;
        out_next.word_matched = matched;
        out_next.word_length  = done ? OUT_LEN_W'(len_w) : '0;
        out_next.word_start   = done ? start_w : '0;
        out_next.match_tally  = OUT_COUNT_W'(count_w);
        out_next.stream_done  = last;

        letters_next = letters_reg;
        pos_ok_next  = pos_ok_reg;
        len_next     = len_reg;
        start_next   = start_reg;
        offset_next  = offset_reg;
        count_next   = count_reg;
        if (accept) begin
            if (done || last) begin
                letters_next = '0;
                pos_ok_next  = 1'b1;
                len_next     = '0;
                start_next   = '0;
            end else begin
                letters_next = letters_w;
                pos_ok_next  = pos_ok_w;
                len_next     = len_w;
                start_next   = start_w;
            end
            offset_next = last ? '0 : offset_reg + 1'b1;
            count_next  = last ? '0 : count_w;
        end

        out_valid_next = out_valid_reg && !m_ready;
        if (accept && (done || last)) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            letters_reg   <= '0;
            pos_ok_reg    <= 1'b1;
            len_reg       <= '0;
            offset_reg    <= '0;
            start_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            letters_reg   <= letters_next;
            pos_ok_reg    <= pos_ok_next;
            len_reg       <= len_next;
            offset_reg    <= offset_next;
            start_reg     <= start_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload only loads when a new result is produced
    always_ff @(posedge aclk) begin
        if (accept && (done || last)) begin
            out_reg <= out_next;
        end
    end

endmodule

@@ rtl/wwf_checker.sv @@
// Port-level checker for the wildcard word filter, bound to the top level.
// Depends on wwf_pkg and wildcard_word_filter_unit_macros.svh.
`include "wildcard_word_filter_unit_macros.svh"

module wwf_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input wwf_pkg::wwf_result_t m_result
);
    import wwf_pkg::*;

    // a stalled result word holds
    `WWF_ASSERT_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_result), "result changed while stalled")

    // a result without a finished word only comes at stream end, and is empty
    `WWF_ASSERT_NOW(a_empty_at_end, m_valid && !m_result.word_done, m_result.stream_done && !m_result.word_matched && (m_result.word_length == '0) && (m_result.word_start == '0), "empty result outside stream end")

    // a finished word always has a length
    `WWF_ASSERT_NOW(a_done_len, m_valid && m_result.word_done, m_result.word_length != '0, "finished word with zero length")

endmodule

bind wildcard_word_filter_unit wwf_checker u_wwf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_result (m_result)
);

@@ dv/wildcard_word_filter_check.sv @@
// Checker for the wildcard word filter: watches both word channels and the APB port,
// predicts each verdict from its own copy of the filter state and compares it.
// Depends on wwf_pkg for the payload structs, register indexes and character codes.
module wildcard_word_filter_check #(
    parameter int MAX_WORD_CHARS = 26
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  wwf_pkg::wwf_item_t         s_item,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  wwf_pkg::wwf_result_t       m_result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [wwf_pkg::ADDR_W-1:0] paddr,
    input  logic [wwf_pkg::DATA_W-1:0] pwdata,
    output int                         errors,
    output int                         verdicts_waiting,
    output int                         words_checked,
    output int                         matches_checked
);
    import wwf_pkg::*;

    localparam logic [4:0] LEN_SAT = 5'(MAX_WORD_CHARS + 1);

    // filter settings as last written over APB
    logic [63:0] pattern_regs [PAT_REGS];
    logic [4:0]  pattern_len;
    logic [25:0] exclude_mask;
    logic [25:0] include_mask;

    // per-word and per-stream state
    logic [25:0] letters_seen;
    logic        positions_ok;
    logic [4:0]  word_len;
    logic [31:0] byte_offset;
    logic [31:0] word_start;
    logic [31:0] match_total;

    wwf_result_t verdicts_due [$];

    function automatic void clear_word();
        letters_seen = '0;
        positions_ok = 1'b1;
        word_len     = '0;
        word_start   = '0;
    endfunction

    task automatic judge_byte(input wwf_item_t word);
        logic [7:0]  b;
        logic [7:0]  pat;
        logic [4:0]  pos;
        logic        last;
        logic        term;
        logic        done;
        wwf_result_t verdict;
        b       = word.text_byte;
        last    = word.stream_end;
        term    = (b == CHAR_LF) || (b == CHAR_CR);
        done    = 1'b0;
        verdict = '0;
        if (!term) begin
            pos = word_len;
            if (pos == 0) begin
                word_start = byte_offset;
            end
            // positions at or past MAX_WORD_CHARS are never compared
            if (pos < MAX_WORD_CHARS) begin
                pat = pattern_regs[pos[4:3]][pos[2:0]*8 +: 8];
                if (pat != CHAR_WILDCARD && pat != b) begin
                    positions_ok = 1'b0;
                end
            end
            if ((b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ||
                (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z)) begin
                letters_seen[5'((b | CASE_BIT) - CHAR_LOWER_A)] = 1'b1;
            end
            if (word_len < LEN_SAT) begin
                word_len++;
            end
        end
        byte_offset++;
        if ((term || last) && word_len != 0) begin
            done                 = 1'b1;
            verdict.word_done    = 1'b1;
            verdict.word_length  = word_len;
            verdict.word_start   = word_start;
            verdict.word_matched = positions_ok
                && pattern_len >= PAT_LEN_MIN
                && pattern_len <= MAX_WORD_CHARS
                && word_len == pattern_len
                && (letters_seen & exclude_mask) == '0
                && (letters_seen & include_mask) == include_mask;
            if (verdict.word_matched && match_total != '1) begin
                match_total++;
            end
            clear_word();
        end
        if (done || last) begin
            verdict.match_tally = match_total;
            verdict.stream_done = last;
            verdicts_due.push_back(verdict);
        end
        if (last) begin
            clear_word();
            byte_offset = '0;
            match_total = '0;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        wwf_result_t want;
        logic [2:0]  idx;
        if (!aresetn) begin
            for (int k = 0; k < PAT_REGS; k++) begin
                pattern_regs[k] = '0;
            end
            pattern_len     = PAT_LEN_RESET;
            exclude_mask    = '0;
            include_mask    = '0;
            byte_offset     = '0;
            match_total     = '0;
            clear_word();
            verdicts_due.delete();
            errors          = 0;
            words_checked   = 0;
            matches_checked = 0;
        end else begin
            // compare before predicting so a stray result is never hidden
            if (m_valid && m_ready) begin
                if (verdicts_due.size() == 0) begin
                    $display("%0t: result with none expected, got %0h", $time, m_result);
                    errors++;
                end else begin
                    want = verdicts_due.pop_front();
                    check_field("word_done", want.word_done, m_result.word_done);
                    check_field("word_matched", want.word_matched, m_result.word_matched);
                    check_field("word_length", want.word_length, m_result.word_length);
                    check_field("word_start", want.word_start, m_result.word_start);
                    check_field("match_tally", want.match_tally, m_result.match_tally);
                    check_field("stream_done", want.stream_done, m_result.stream_done);
                    words_checked   += want.word_done;
                    matches_checked += want.word_matched;
                end
            end
            if (s_valid && s_ready) begin
                judge_byte(s_item);
            end
            if (psel && penable && pwrite && pready) begin
                idx = paddr[5:3];
                case (idx)
                    REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3: begin
                        pattern_regs[idx[1:0]] = pwdata;
                    end
                    REG_PAT_LEN: pattern_len = pwdata[4:0];
                    REG_EXCL: exclude_mask = pwdata[25:0];
                    REG_INCL: include_mask = pwdata[25:0];
                    default: ;
                endcase
            end
        end
        verdicts_waiting = verdicts_due.size();
    end

endmodule

@@ dv/wildcard_word_filter_unit_test.sv @@
// Testbench top for wildcard_word_filter_unit: clock, reset, APB setup and word stimulus.
// Checking lives in wildcard_word_filter_check; this module only drives and gives the verdict.
// Depends on wwf_pkg and the two modules above.
module wildcard_word_filter_unit_test;
    import wwf_pkg::*;

    localparam int         MAX_CHARS      = 26;
    localparam int         PHASES         = 8;
    localparam int         PHASE_BYTES    = 225;
    localparam int         WATCHDOG_LIMIT = 1000;
    localparam int         SETTLE_CYCLES  = 4;
    localparam logic [2:0] REG_UNUSED     = 3'd7;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    wwf_item_t           s_item;
    logic                m_valid;
    logic                m_ready;
    wwf_result_t         m_result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int errors;
    int verdicts_waiting;
    int words_checked;
    int matches_checked;

    bit          no_gaps;
    int          bytes_sent;
    int          settings_used;
    logic [7:0]  pat_bytes [32];
    logic [4:0]  pat_len_cfg;
    logic [25:0] excl_cfg;
    logic [25:0] incl_cfg;
    logic [7:0]  word_bytes [$];

    wildcard_word_filter_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    wildcard_word_filter_check chk (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_item           (s_item),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result         (m_result),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .errors           (errors),
        .verdicts_waiting (verdicts_waiting),
        .words_checked    (words_checked),
        .matches_checked  (matches_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            m_ready <= no_gaps || ($urandom_range(99) >= 16);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [7:0] random_letter();
        if ($urandom_range(1)) begin
            return 8'(CHAR_UPPER_A + $urandom_range(25));
        end
        return 8'(CHAR_LOWER_A + $urandom_range(25));
    endfunction

    function automatic logic [7:0] any_text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == CHAR_LF || b == CHAR_CR);
        return b;
    endfunction

    // filler for a wildcard slot; steers clear of excluded letters most of the time
    function automatic logic [7:0] free_char();
        logic [7:0] c;
        if ($urandom_range(99) < 10) begin
            return 8'(CHAR_ZERO + $urandom_range(9));
        end
        for (int t = 0; t < 6; t++) begin
            c = random_letter();
            if (!excl_cfg[5'((c | CASE_BIT) - CHAR_LOWER_A)]) begin
                return c;
            end
        end
        return 8'(CHAR_ZERO + $urandom_range(9));
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!no_gaps && $urandom_range(99) < 10) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_item          <= '{text_byte: b, stream_end: last};
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    // hold the sender until every verdict is back, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (verdicts_waiting != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_filter(input int phase);
        logic [63:0] regs [PAT_REGS];
        logic [25:0] fixed;
        int          r;
        fixed       = '0;
        pat_len_cfg = 5'($urandom_range(2, ($urandom_range(3) == 0) ? MAX_CHARS : 8));
        for (int k = 0; k < 32; k++) begin
            r = $urandom_range(99);
            if (r < 30) begin
                pat_bytes[k] = CHAR_WILDCARD;
            end else if (r < 90) begin
                pat_bytes[k] = random_letter();
            end else begin
                pat_bytes[k] = 8'(CHAR_ZERO + $urandom_range(9));
            end
        end
        case (phase)
            0: begin
                pat_len_cfg = 5'(MAX_CHARS);
                for (int k = 0; k < 32; k++) pat_bytes[k] = CHAR_WILDCARD;
            end
            2: begin
                // lengths outside 2..26 reject every word
                case ($urandom_range(3))
                    0: pat_len_cfg = 5'd0;
                    1: pat_len_cfg = 5'd1;
                    2: pat_len_cfg = 5'd27;
                    default: pat_len_cfg = 5'd31;
                endcase
            end
            4: begin
                pat_len_cfg = PAT_LEN_MIN;
                for (int k = 0; k < 32; k++) pat_bytes[k] = 8'hFF;
            end
            default: ;
        endcase
        for (int k = 0; k < MAX_CHARS; k++) begin
            if ((pat_bytes[k] >= CHAR_UPPER_A && pat_bytes[k] <= CHAR_UPPER_Z) ||
                (pat_bytes[k] >= CHAR_LOWER_A && pat_bytes[k] <= CHAR_LOWER_Z)) begin
                fixed[5'((pat_bytes[k] | CASE_BIT) - CHAR_LOWER_A)] = 1'b1;
            end
        end
        excl_cfg = 26'($urandom) & ~fixed;
        if ($urandom_range(1)) begin
            excl_cfg &= 26'($urandom);
        end
        incl_cfg = fixed & 26'($urandom);
        if (phase == 0) begin
            excl_cfg = '0;
            incl_cfg = '0;
        end else if (phase == 1) begin
            excl_cfg = '1;
            incl_cfg = '1;
        end
        for (int k = 0; k < 32; k++) begin
            regs[k / 8][(k % 8) * 8 +: 8] = pat_bytes[k];
        end
        write_reg(REG_PAT0, regs[0]);
        write_reg(REG_PAT1, regs[1]);
        write_reg(REG_PAT2, regs[2]);
        write_reg(REG_PAT3, regs[3]);
        write_reg(REG_PAT_LEN, {$urandom, 27'($urandom), pat_len_cfg});
        write_reg(REG_EXCL, {$urandom, 6'($urandom), excl_cfg});
        write_reg(REG_INCL, {$urandom, 6'($urandom), incl_cfg});
        if (phase == 5) begin
            write_reg(REG_UNUSED, {$urandom, $urandom});
        end
        settings_used++;
    endtask

    // mostly pattern-shaped words, some off by a byte or a length, some long, some noise
    task automatic make_word();
        int kind;
        int n;
        word_bytes.delete();
        kind = $urandom_range(99);
        n    = (pat_len_cfg < 2) ? 2 : ((pat_len_cfg > MAX_CHARS) ? MAX_CHARS : pat_len_cfg);
        if (kind < 76) begin
            for (int k = 0; k < n; k++) begin
                word_bytes.push_back((pat_bytes[k] == CHAR_WILDCARD) ? free_char()
                                                                     : pat_bytes[k]);
            end
            if (kind >= 50 && kind < 62) begin
                word_bytes[$urandom_range(n - 1)] = any_text_byte();
            end else if (kind >= 62 && kind < 70) begin
                if ($urandom_range(1)) begin
                    word_bytes.push_back(free_char());
                end else begin
                    void'(word_bytes.pop_back());
                end
            end else if (kind >= 70) begin
                repeat ($urandom_range(MAX_CHARS + 1 - n, MAX_CHARS + 8 - n)) begin
                    word_bytes.push_back(any_text_byte());
                end
            end
        end else begin
            repeat ($urandom_range(1, 12)) word_bytes.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic send_word();
        int ending;
        int n;
        ending = $urandom_range(99);
        for (int k = 0; k < word_bytes.size(); k++) begin
            send_byte(word_bytes[k], ending < 4 && k == word_bytes.size() - 1);
        end
        if (ending >= 4 || word_bytes.size() == 0) begin
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++) begin
                send_byte($urandom_range(1) ? CHAR_LF : CHAR_CR, ending < 8 && k == n - 1);
            end
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_item        = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        no_gaps       = 1'b0;
        bytes_sent    = 0;
        settings_used = 1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: all-zero pattern of length 2, no letter masks
        send_byte(CHAR_LF, 1'b0); send_byte(CHAR_CR, 1'b0);
        send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(CHAR_LF, 1'b0);
        send_byte(8'hFF, 1'b0); send_byte(CHAR_CR, 1'b0);
        // stream ends on a letter, then on a bare terminator, then on a lone byte
        send_byte(CHAR_LOWER_A, 1'b0); send_byte(CHAR_UPPER_Z, 1'b1);
        send_byte(CHAR_CR, 1'b1);
        send_byte(8'h00, 1'b1);
        // an underscore in the text is just a byte
        send_byte(CHAR_WILDCARD, 1'b0); send_byte(8'h7F, 1'b0);
        send_byte(CHAR_LF, 1'b0); send_byte(CHAR_LF, 1'b0);
        send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
        send_byte(CHAR_CR, 1'b0);
        // bytes just outside the letter ranges
        send_byte(8'(CHAR_UPPER_A - 1), 1'b0); send_byte(8'(CHAR_UPPER_Z + 1), 1'b0);
        send_byte(8'(CHAR_LOWER_A - 1), 1'b0); send_byte(8'(CHAR_LOWER_Z + 1), 1'b0);
        send_byte(CHAR_LF, 1'b0);
        send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(CHAR_CR, 1'b1);
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            no_gaps = (phase == 3);
            set_filter(phase);
            if (phase == 0) begin
                // full-length all-wildcard word, then one longer than the length limit
                repeat (MAX_CHARS) send_byte(8'(CHAR_LOWER_A + 16), 1'b0);
                send_byte(CHAR_LF, 1'b0);
                repeat (MAX_CHARS + 4) send_byte(any_text_byte(), 1'b0);
                send_byte(CHAR_CR, 1'b0);
            end
            while (bytes_sent < 60 + (phase + 1) * PHASE_BYTES) begin
                make_word();
                send_word();
            end
            drain();
        end

        $display("Sent %0d bytes under %0d filter settings.", bytes_sent, settings_used);
        $display("Checked %0d word verdicts, %0d of them matches.",
                 words_checked, matches_checked);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/wwf_pkg.sv
rtl/wildcard_word_filter_unit.sv
rtl/wwf_checker.sv
dv/wildcard_word_filter_check.sv
dv/wildcard_word_filter_unit_test.sv
